[rtl/core/bpvm_pkg.sv]
// bpvm_pkg: word types and fixed constants for the bar pattern variance match block
// no dependencies; used by bar_pattern_variance_match and bpvm_checker
package bpvm_pkg;

  localparam int RUN_WIDTH_W = 12;
  localparam int MODULES_W   = 4;
  localparam int MEV_W       = 10;
  localparam int AVG_W       = 13;

  localparam logic [MEV_W-1:0] MEV_RESET = 10'd179;

  typedef struct packed {
    logic [RUN_WIDTH_W-1:0] run_width;
    logic [MODULES_W-1:0]   pattern_modules;
    logic                   last_element;
  } in_word_t;

  typedef struct packed {
    logic             match_ok;
    logic [AVG_W-1:0] average_variance;
  } out_word_t;

endpackage

[rtl/core/bar_pattern_variance_match.sv]
// bar_pattern_variance_match: top level, element store, sequencer and shared serial divider
// depends on bpvm_pkg
//
// Elements load one per cycle into a small store while in_stall is low; a word that is not
// marked last is taken and gives no result. A word marked last starts the evaluation and holds
// in_stall high until its result sits in the output register: a check step, a restoring divide
// of (pixel_total << SCALE_SHIFT) by module_total, a limit-multiply step, then for each stored
// element a store read, a multiply and a compare and accumulate, a second divide of the
// variance sum by pixel_total and an output step. Each divide runs one quotient bit per
// cycle on a single shared subtract-and-compare unit and yields a SUM_W-bit quotient, where
// SUM_W = 4 + RUN_W + SCALE_SHIFT + 2*clog2(MAX_ELEMENTS+1), 34 with the defaults. A no-match
// found from the totals alone goes straight from the check to the output step, and one found
// at an element stops the walk there. A new pattern may load while the previous result still
// waits.
module bar_pattern_variance_match #(
  parameter int MAX_ELEMENTS = 16,
  parameter int SCALE_SHIFT  = 8,
  parameter int RUN_BITS     = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  bpvm_pkg::in_word_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output bpvm_pkg::out_word_t                  out_data,
  input  logic                                 cfg_wr_en,
  input  logic [bpvm_pkg::MEV_W-1:0]           cfg_wr_data
);

  localparam int RUN_W  = (RUN_BITS < bpvm_pkg::RUN_WIDTH_W) ? RUN_BITS : bpvm_pkg::RUN_WIDTH_W;
  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int IDX_W  = $clog2(MAX_ELEMENTS);
  localparam int PIX_W  = RUN_W + CNT_W;
  localparam int MOD_W  = bpvm_pkg::MODULES_W + CNT_W;
  localparam int NUM_W  = PIX_W + SCALE_SHIFT;
  localparam int VAR_W  = bpvm_pkg::MODULES_W + NUM_W;
  localparam int PROD_W = bpvm_pkg::MEV_W + NUM_W;
  localparam int LIM_W  = PROD_W - SCALE_SHIFT;
  localparam int CMP_W  = (LIM_W > VAR_W) ? LIM_W : VAR_W;
  localparam int SUM_W  = VAR_W + CNT_W;
  localparam int DCNT_W = $clog2(SUM_W);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_CHK  = 9'b000000010,
    ST_DIV1 = 9'b000000100,
    ST_LIM  = 9'b000001000,
    ST_RD   = 9'b000010000,
    ST_MUL  = 9'b000100000,
    ST_ACC  = 9'b001000000,
    ST_DIV2 = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_t;

  state_t                      state_r, state_nxt;
  logic                        out_valid_r, out_valid_nxt;
  bpvm_pkg::out_word_t         out_data_r, out_data_nxt;
  logic [bpvm_pkg::MEV_W-1:0]  mev_r;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [PIX_W-1:0]            pix_r, pix_nxt;
  logic [MOD_W-1:0]            mod_r, mod_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        ok_r, ok_nxt;
  logic [PIX_W-1:0]            rem_r, rem_nxt;
  logic [SUM_W-1:0]            qn_r, qn_nxt;
  logic [PIX_W-1:0]            den_r, den_nxt;
  logic [DCNT_W-1:0]           dcnt_r, dcnt_nxt;
  logic [NUM_W-1:0]            unit_r, unit_nxt;
  logic [LIM_W-1:0]            limit_r, limit_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic [SUM_W-1:0]            sum_r, sum_nxt;
  logic [VAR_W-1:0]            want_r, want_nxt;
  logic [RUN_W-1:0]            run_rd_r;
  logic [bpvm_pkg::MODULES_W-1:0] mod_rd_r;

  logic [RUN_W-1:0]               run_mem [MAX_ELEMENTS];
  logic [bpvm_pkg::MODULES_W-1:0] mod_mem [MAX_ELEMENTS];

  logic                   in_acc;
  logic                   room;
  logic [RUN_W-1:0]       run_in;
  logic [PIX_W:0]         rem_sh;
  logic [PIX_W:0]         rem_diff;
  logic                   q_bit;
  logic [PIX_W-1:0]       rem_step;
  logic [SUM_W-1:0]       qn_step;
  logic [PROD_W-1:0]      lim_prod;
  logic [VAR_W-1:0]       meas;
  logic [VAR_W-1:0]       var_abs;
  logic                   var_over;
  logic                   idx_last;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && (state_r == ST_IDLE);
  assign room      = (cnt_r < CNT_W'(MAX_ELEMENTS));
  assign run_in    = in_data.run_width[RUN_W-1:0];
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // shared restoring divide step, one quotient bit per cycle
  assign rem_sh   = {rem_r, qn_r[SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, den_r};
  assign q_bit    = (rem_sh >= {1'b0, den_r});
  assign rem_step = q_bit ? rem_diff[PIX_W-1:0] : rem_sh[PIX_W-1:0];
  assign qn_step  = {qn_r[SUM_W-2:0], q_bit};

  assign lim_prod = PROD_W'(mev_r) * PROD_W'(qn_r[NUM_W-1:0]);
  assign meas     = VAR_W'(run_rd_r) << SCALE_SHIFT;
  assign var_abs  = (meas > want_r) ? (meas - want_r) : (want_r - meas);
  assign var_over = (CMP_W'(var_abs) > CMP_W'(limit_r));
  assign idx_last = ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cnt_nxt       = cnt_r;
    pix_nxt       = pix_r;
    mod_nxt       = mod_r;
    ovf_nxt       = ovf_r;
    ok_nxt        = ok_r;
    rem_nxt       = rem_r;
    qn_nxt        = qn_r;
    den_nxt       = den_r;
    dcnt_nxt      = dcnt_r;
    unit_nxt      = unit_r;
    limit_nxt     = limit_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    want_nxt      = want_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (room) begin
            cnt_nxt = cnt_r + CNT_W'(1);
            pix_nxt = pix_r + PIX_W'(run_in);
            mod_nxt = mod_r + MOD_W'(in_data.pattern_modules);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last_element) begin
            state_nxt = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        if (ovf_r || (mod_r == '0) || (pix_r < PIX_W'(mod_r))) begin
          ok_nxt    = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          ok_nxt    = 1'b1;
          rem_nxt   = '0;
          qn_nxt    = SUM_W'(pix_r) << SCALE_SHIFT;
          den_nxt   = PIX_W'(mod_r);
          dcnt_nxt  = DCNT_W'(SUM_W - 1);
          state_nxt = ST_DIV1;
        end
      end
      ST_DIV1: begin
        rem_nxt = rem_step;
        qn_nxt  = qn_step;
        if (dcnt_r == '0) begin
          state_nxt = ST_LIM;
        end else begin
          dcnt_nxt = dcnt_r - DCNT_W'(1);
        end
      end
      ST_LIM: begin
        unit_nxt  = qn_r[NUM_W-1:0];
        limit_nxt = lim_prod[PROD_W-1:SCALE_SHIFT];
        idx_nxt   = '0;
        sum_nxt   = '0;
        state_nxt = ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        want_nxt  = VAR_W'(mod_rd_r) * VAR_W'(unit_r);
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (var_over) begin
          ok_nxt    = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          sum_nxt = sum_r + SUM_W'(var_abs);
          if (idx_last) begin
            rem_nxt   = '0;
            qn_nxt    = sum_r + SUM_W'(var_abs);
            den_nxt   = pix_r;
            dcnt_nxt  = DCNT_W'(SUM_W - 1);
            state_nxt = ST_DIV2;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = ST_RD;
          end
        end
      end
      ST_DIV2: begin
        rem_nxt = rem_step;
        qn_nxt  = qn_step;
        if (dcnt_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          dcnt_nxt = dcnt_r - DCNT_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.match_ok         = ok_r;
          out_data_nxt.average_variance = ok_r ? qn_r[bpvm_pkg::AVG_W-1:0] : '0;
          cnt_nxt                       = '0;
          pix_nxt                       = '0;
          mod_nxt                       = '0;
          ovf_nxt                       = 1'b0;
          state_nxt                     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      mev_r       <= bpvm_pkg::MEV_RESET;
      cnt_r       <= '0;
      pix_r       <= '0;
      mod_r       <= '0;
      ovf_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      pix_r       <= pix_nxt;
      mod_r       <= mod_nxt;
      ovf_r       <= ovf_nxt;
      if (cfg_wr_en) begin
        mev_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    ok_r       <= ok_nxt;
    rem_r      <= rem_nxt;
    qn_r       <= qn_nxt;
    den_r      <= den_nxt;
    dcnt_r     <= dcnt_nxt;
    unit_r     <= unit_nxt;
    limit_r    <= limit_nxt;
    idx_r      <= idx_nxt;
    sum_r      <= sum_nxt;
    want_r     <= want_nxt;
  end

  // element store
  always_ff @(posedge clk) begin
    if (in_acc && room) begin
      run_mem[cnt_r[IDX_W-1:0]] <= run_in;
      mod_mem[cnt_r[IDX_W-1:0]] <= in_data.pattern_modules;
    end
    if (state_r == ST_RD) begin
      run_rd_r <= run_mem[idx_r];
      mod_rd_r <= mod_mem[idx_r];
    end
  end

endmodule

[rtl/core/bpvm_checker.sv]
// bpvm_checker: port-level assertions for bar_pattern_variance_match, bound to the top level
// depends on bpvm_pkg and bar_pattern_variance_match
module bpvm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input bpvm_pkg::in_word_t         in_data,
  input logic                       out_valid,
  input logic                       out_stall,
  input bpvm_pkg::out_word_t        out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // a last element starts evaluation and blocks the input
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last_element |=> in_stall)
    else $error("input not blocked after last element");

  // an inner element never blocks the next one
  a_inner_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_data.last_element |=> !in_stall)
    else $error("input blocked after inner element");

  // reset leaves no result word pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result or stall present after reset");

endmodule

bind bar_pattern_variance_match bpvm_checker u_bpvm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[test/tb_bar_pattern_variance_match.sv]
// tb_bar_pattern_variance_match: self-checking bench for the bar pattern variance match block
// drives element words with random gaps, predicts each pattern verdict and checks every result
// depends on bpvm_pkg and bar_pattern_variance_match
`timescale 1ns / 100ps

module tb_bar_pattern_variance_match;

  localparam int MAX_ELEMENTS = 16;
  localparam int SCALE_SHIFT  = 8;
  localparam int RUN_BITS     = 12;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 150;
  localparam int REPORT_LIMIT = 10;
  localparam int PHASE_ITEMS  = 210;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  bpvm_pkg::in_word_t         in_data = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  bpvm_pkg::out_word_t        out_data;
  logic                       cfg_wr_en = 1'b0;
  logic [bpvm_pkg::MEV_W-1:0] cfg_wr_data = '0;

  logic [bpvm_pkg::RUN_WIDTH_W-1:0] stored_runs [MAX_ELEMENTS];
  logic [bpvm_pkg::MODULES_W-1:0]   stored_modules [MAX_ELEMENTS];
  int unsigned                      loaded_count = 0;
  logic [31:0]                      run_sum = '0;
  logic [31:0]                      module_sum = '0;
  logic                             pattern_overflow = 1'b0;
  logic [bpvm_pkg::MEV_W-1:0]       limit_setting = bpvm_pkg::MEV_RESET;

  bpvm_pkg::out_word_t expected_scores [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  int unsigned items_sent = 0;
  bit          quiet = 1'b0;

  always #4 clk = ~clk;

  bar_pattern_variance_match #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .SCALE_SHIFT (SCALE_SHIFT),
    .RUN_BITS    (RUN_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  function automatic int unsigned draw_gap();
    if (quiet) return 0;
    return $urandom_range(0, 7);
  endfunction

  function automatic bpvm_pkg::out_word_t judge_pattern();
    logic [63:0]         unit, limit, sum, meas, want, diff;
    bpvm_pkg::out_word_t verdict;
    int unsigned         k;
    verdict = '0;
    if (pattern_overflow || module_sum == 0 || run_sum < module_sum) return verdict;
    unit  = (64'(run_sum) << SCALE_SHIFT) / 64'(module_sum);
    limit = (64'(limit_setting) * unit) >> SCALE_SHIFT;
    sum   = '0;
    for (k = 0; k < loaded_count; k++) begin
      meas = 64'(stored_runs[k]) << SCALE_SHIFT;
      want = 64'(stored_modules[k]) * unit;
      diff = (meas > want) ? meas - want : want - meas;
      if (diff > limit) return verdict;
      sum += diff;
    end
    verdict.match_ok = 1'b1;
    verdict.average_variance = bpvm_pkg::AVG_W'(sum / 64'(run_sum));
    return verdict;
  endfunction

  task automatic score_element(bpvm_pkg::in_word_t w);
    logic [bpvm_pkg::RUN_WIDTH_W-1:0] run;
    run = w.run_width & bpvm_pkg::RUN_WIDTH_W'((1 << RUN_BITS) - 1);
    if (loaded_count < MAX_ELEMENTS) begin
      stored_runs[loaded_count] = run;
      stored_modules[loaded_count] = w.pattern_modules;
      loaded_count++;
      run_sum += run;
      module_sum += w.pattern_modules;
    end else begin
      pattern_overflow = 1'b1;
    end
    if (w.last_element) begin
      expected_scores.push_back(judge_pattern());
      loaded_count = 0;
      run_sum = '0;
      module_sum = '0;
      pattern_overflow = 1'b0;
    end
  endtask

  task automatic send_element(int unsigned run, int unsigned mods, bit last);
    bpvm_pkg::in_word_t w;
    int unsigned        gap;
    w.run_width = bpvm_pkg::RUN_WIDTH_W'(run);
    w.pattern_modules = bpvm_pkg::MODULES_W'(mods);
    w.last_element = last;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    score_element(w);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [bpvm_pkg::MEV_W-1:0] value);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    limit_setting = value;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic check_score(bpvm_pkg::out_word_t got);
    bpvm_pkg::out_word_t want;
    if (expected_scores.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: result with none pending: match_ok %0b average_variance %0d",
                 $time, got.match_ok, got.average_variance);
      return;
    end
    want = expected_scores.pop_front();
    if (got.match_ok !== want.match_ok || got.average_variance !== want.average_variance) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: match_ok exp %0b got %0b, average_variance exp %0d got %0d",
                 $time, want.match_ok, got.match_ok, want.average_variance,
                 got.average_variance);
    end
  endtask

  task automatic send_random_pattern();
    int unsigned n, unit_px, span, mods, pick, k;
    int          value;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // unstructured words
      n = $urandom_range(1, 6);
      for (k = 0; k < n; k++)
        send_element($urandom_range(0, 4095), $urandom_range(0, 15), k == n - 1);
      return;
    end
    if (pick < 70) n = $urandom_range(2, 9);
    else if (pick < 85) n = $urandom_range(10, 16);
    else if (pick < 90) n = 1;
    else n = $urandom_range(17, 20);
    unit_px = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 24);
    case ($urandom_range(0, 3))
      0: span = 0;
      1: span = unit_px / 4;
      2: span = unit_px / 2;
      default: span = unit_px;
    endcase
    for (k = 0; k < n; k++) begin
      mods = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
      value = int'(mods * unit_px) + int'($urandom_range(0, 2 * span)) - int'(span);
      if (value < 0) value = 0;
      if (value > 4095) value = 4095;
      send_element(value, mods, k == n - 1);
    end
  endtask

  task automatic test_directed_cases();
    int unsigned k;
    // one pattern with a small deviation on its second element
    send_element(20, 2, 1'b0);
    send_element(11, 1, 1'b0);
    send_element(30, 3, 1'b1);
    // zero pattern total
    send_element(0, 0, 1'b1);
    // widest run on widest element
    send_element(4095, 15, 1'b1);
    // fewer pixels than modules
    send_element(1, 15, 1'b1);
    // elements over the limit
    send_element(4, 1, 1'b0);
    send_element(36, 1, 1'b1);
    // one element too many
    for (k = 0; k < MAX_ELEMENTS; k++) send_element(1, 1, 1'b0);
    send_element(1, 1, 1'b1);
  endtask

  task automatic test_limit_extremes();
    int unsigned k;
    write_limit('0);
    send_element(8, 2, 1'b0);
    send_element(4, 1, 1'b1);
    for (k = 0; k < 12; k++) send_random_pattern();
    write_limit('1);
    for (k = 0; k < 12; k++) send_random_pattern();
  endtask

  task automatic test_random_traffic();
    logic [bpvm_pkg::MEV_W-1:0] settings [8];
    int unsigned                phase, start;
    settings = '{bpvm_pkg::MEV_RESET, 10'd1, 10'd1023, 10'd0, 10'd512, 10'd0, 10'd0, 10'd0};
    settings[3] = bpvm_pkg::MEV_W'($urandom_range(0, 1023));
    settings[6] = bpvm_pkg::MEV_W'($urandom_range(0, 1023));
    settings[7] = bpvm_pkg::MEV_W'($urandom_range(0, 1023));
    for (phase = 0; phase < 8; phase++) begin
      write_limit(settings[phase]);
      quiet = (phase == 2 || phase == 5);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) send_random_pattern();
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && !out_stall) begin
        check_score(out_data);
        hold_left = draw_gap();
      end else if (hold_left != 0) begin
        hold_left--;
      end
      out_stall <= (hold_left != 0);
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_limit_extremes();
    test_random_traffic();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
